// ----- rtl/spimbt_pkg.sv -----
// ----------------------------------------------------------------------------
// SPI master byte transfer package
// Shared types and constants for the SPI master byte transfer unit.
// ----------------------------------------------------------------------------
package spimbt_pkg;

   localparam int unsigned DIVISOR_W    = 16;
   localparam int unsigned SELECT_W     = 32;
   localparam int unsigned CSR_ADDR_W   = 2;
   localparam int unsigned REQ_DATA_W   = 48;
   localparam int unsigned RSP_DATA_W   = 48;

   localparam logic [DIVISOR_W-1:0] DIVISOR_RESET = 16'd124;

   typedef enum logic [1:0] {
      REQ_TICK     = 2'd0,
      REQ_START    = 2'd1,
      REQ_SELECT   = 2'd2,
      REQ_RESERVED = 2'd3
   } req_kind_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_DIVISOR  = 2'd0,
      CSR_POLARITY = 2'd1,
      CSR_PHASE    = 2'd2,
      CSR_UNUSED   = 2'd3
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_DELAY  = 4'b0010,
      ST_FIRST  = 4'b0100,
      ST_SECOND = 4'b1000
   } phase_state_type;

   typedef struct packed {
      logic [DIVISOR_W-1:0] half_period_divisor;
      logic                 clock_polarity;
      logic                 clock_phase;
   } cfg_type;

   typedef struct packed {
      logic [7:0]          rx_byte;
      logic                is_ready;
      logic [SELECT_W-1:0] select_lines;
      logic                mosi_bit;
      logic                sclk_level;
   } rsp_fields_type;

endpackage

// ----- rtl/spimbt_engine.sv -----
// ----------------------------------------------------------------------------
// SPI master sequencing engine
// Holds the half-period counter, bit counter, shift registers and select
// register, and forms the bus levels that follow each tick.
// ----------------------------------------------------------------------------
module spimbt_engine #(
   parameter int unsigned SELECT_LINES = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            advance,
   input  spimbt_pkg::req_kind_type        req_kind,
   input  logic [7:0]                      tx_byte,
   input  logic [spimbt_pkg::SELECT_W-1:0] select_word,
   input  logic                            miso_bit,
   input  spimbt_pkg::cfg_type             cfg,
   output spimbt_pkg::rsp_fields_type      result
);
   import spimbt_pkg::*;

   phase_state_type         state_ff, state_in;
   logic [DIVISOR_W-1:0]    count_ff, count_in;
   logic [2:0]              bit_ff, bit_in;
   logic [7:0]              tx_ff, tx_in;
   logic [7:0]              rx_ff, rx_in;
   logic [SELECT_LINES-1:0] select_ff, select_in;
   logic                    at_end;
   logic [DIVISOR_W-1:0]    count_inc;
   logic                    pclk;

   assign at_end    = (count_ff == cfg.half_period_divisor);
   assign count_inc = count_ff + DIVISOR_W'(1);

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      bit_in    = bit_ff;
      tx_in     = tx_ff;
      rx_in     = rx_ff;
      select_in = (req_kind == REQ_SELECT) ? select_word[SELECT_LINES-1:0] : select_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_kind == REQ_START) begin
               tx_in    = tx_byte;
               bit_in   = 3'd0;
               count_in = '0;
               state_in = cfg.clock_phase ? ST_DELAY : ST_FIRST;
            end
         end
         ST_DELAY: begin
            if (at_end) begin
               state_in = ST_FIRST;
               count_in = '0;
            end else begin
               count_in = count_inc;
            end
         end
         ST_FIRST: begin
            if (at_end) begin
               rx_in    = {rx_ff[6:0], miso_bit};
               state_in = ST_SECOND;
               count_in = '0;
            end else begin
               count_in = count_inc;
            end
         end
         ST_SECOND: begin
            if (at_end) begin
               if (bit_ff == 3'd7) begin
                  state_in = ST_IDLE;
               end else begin
                  tx_in    = {tx_ff[6:0], 1'b0};
                  bit_in   = bit_ff + 3'd1;
                  state_in = ST_FIRST;
               end
               count_in = '0;
            end else begin
               count_in = count_inc;
            end
         end
         default: begin
            state_in = ST_IDLE;
            count_in = '0;
         end
      endcase
   end

   assign pclk = ((state_in == ST_SECOND) && !cfg.clock_phase) ||
                 ((state_in == ST_FIRST) && cfg.clock_phase);

   assign result.sclk_level   = pclk ^ cfg.clock_polarity;
   assign result.mosi_bit     = tx_in[7];
   assign result.select_lines = SELECT_W'(select_in);
   assign result.is_ready     = (state_in == ST_IDLE);
   assign result.rx_byte      = rx_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         bit_ff    <= 3'd0;
         tx_ff     <= 8'd0;
         rx_ff     <= 8'd0;
         select_ff <= '1;
      end else if (advance) begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         bit_ff    <= bit_in;
         tx_ff     <= tx_in;
         rx_ff     <= rx_in;
         select_ff <= select_in;
      end
   end

endmodule

// ----- rtl/spi_master_byte_transfer_unit.sv -----
// ----------------------------------------------------------------------------
// SPI master byte transfer unit
// SPI master for single byte transfers in modes 0 to 3. Every request beat
// is one timing tick and may start a transfer or write the select lines;
// every tick returns one response beat with the bus levels after it.
//
//   Channel   Direction  Contents
//   req_*     in         tuser: request kind; tdata: tx byte, select, miso
//   rsp_*     out        tdata: sclk, mosi, select, ready, rx byte
//   csr_*     in         register writes: divisor, polarity, phase
//
// One request beat is taken every cycle unless stalled; its response beat
// is registered and appears the cycle after. The single response register
// sets the rate: a new beat is taken whenever that register is empty or
// being drained. A stalled response holds and blocks further requests.
// Reset is synchronous and returns the core to idle with selects high.
// ----------------------------------------------------------------------------
module spi_master_byte_transfer_unit #(
   parameter int unsigned SELECT_LINES = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [1:0]                        req_tuser,  // req_kind_type
   input  logic [spimbt_pkg::REQ_DATA_W-1:0] req_tdata,  // tx_byte, select_word, miso_bit
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // sclk_level, mosi_bit, select_lines, is_ready, rx_byte
   output logic [spimbt_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                              csr_we,
   input  logic [spimbt_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [spimbt_pkg::DIVISOR_W-1:0]  csr_wdata
);
   import spimbt_pkg::*;

   cfg_type        cfg_ff;
   logic           rsp_valid_ff;
   rsp_fields_type rsp_ff;
   rsp_fields_type result;
   logic           accept;
   req_kind_type   req_kind;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign req_kind   = req_kind_type'(req_tuser);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.half_period_divisor <= DIVISOR_RESET;
         cfg_ff.clock_polarity      <= 1'b0;
         cfg_ff.clock_phase         <= 1'b0;
      end else if (csr_we) begin
         case (csr_index_type'(csr_addr))
            CSR_DIVISOR:  cfg_ff.half_period_divisor <= csr_wdata;
            CSR_POLARITY: cfg_ff.clock_polarity      <= csr_wdata[0];
            CSR_PHASE:    cfg_ff.clock_phase         <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   spimbt_engine #(
      .SELECT_LINES (SELECT_LINES)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .advance     (accept),
      .req_kind    (req_kind),
      .tx_byte     (req_tdata[7:0]),
      .select_word (req_tdata[39:8]),
      .miso_bit    (req_tdata[40]),
      .cfg         (cfg_ff),
      .result      (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_tready) begin
         rsp_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_ff);

endmodule

// ----- rtl/spimbt_checker.sv -----
// ----------------------------------------------------------------------------
// SPI master byte transfer checker
// Port-level checks on the request and response channels.
// ----------------------------------------------------------------------------
module spimbt_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [spimbt_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import spimbt_pkg::*;

   // Every accepted request beat yields a response beat on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> rsp_tvalid)
      else $error("request beat produced no response beat");

   // A waiting response must hold back further requests.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |-> !req_tready)
      else $error("request taken while a response beat was stalled");

   // A stalled response beat keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled response beat changed");

   // Padding above the packed fields stays zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[RSP_DATA_W-1:43] == '0))
      else $error("response padding bits are not zero");

endmodule

bind spi_master_byte_transfer_unit spimbt_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
